// ----- hw/rtl/ntp_pkg.sv -----
// ----------------------------------------------------------------------------
// ntp_pkg - note-to-pitch interpolator package
// Shared widths, constants and the pitch table lookup.
// ----------------------------------------------------------------------------
package ntp_pkg;

    localparam int VOICE_W   = 5;
    localparam int NOTE_W    = 16;
    localparam int TUNE_W    = 8;
    localparam int OFFS_W    = 8;
    localparam int PITCH_W   = 14;
    localparam int IDX_W     = 7;
    localparam int ADDR_W    = IDX_W + 1;   // idx+1 may reach 128
    localparam int FRAC_W    = 8;
    localparam int DLO_W     = 8;
    localparam int DHI_W     = PITCH_W - DLO_W;

    // number of populated table entries; addresses at or past it read zero
    localparam int TABLE_ENTRIES = 108;

    // difference used when the table steps down
    localparam logic [PITCH_W-1:0] NEG_DIFF = PITCH_W'(16'h00C9);

    typedef logic [VOICE_W-1:0] t_voice;
    typedef logic [PITCH_W-1:0] t_pitch;

    // stage control shared by all pipeline stages
    typedef struct packed {
        logic en;    // stage advances this cycle
    } t_pipe_ctl;

    function automatic t_pitch pitch_rom(input logic [ADDR_W-1:0] addr);
        logic [15:0] v;
        case (addr)
            8'd0:   v = 16'h010B;  8'd1:   v = 16'h011B;  8'd2:   v = 16'h012C;
            8'd3:   v = 16'h013E;  8'd4:   v = 16'h0151;  8'd5:   v = 16'h0165;
            8'd6:   v = 16'h017A;  8'd7:   v = 16'h0191;  8'd8:   v = 16'h01A9;
            8'd9:   v = 16'h01C2;  8'd10:  v = 16'h01DD;  8'd11:  v = 16'h01F9;
            8'd12:  v = 16'h0217;  8'd13:  v = 16'h0237;  8'd14:  v = 16'h0259;
            8'd15:  v = 16'h027D;  8'd16:  v = 16'h02A3;  8'd17:  v = 16'h02CB;
            8'd18:  v = 16'h02F5;  8'd19:  v = 16'h0322;  8'd20:  v = 16'h0352;
            8'd21:  v = 16'h0385;  8'd22:  v = 16'h03BA;  8'd23:  v = 16'h03F3;
            8'd24:  v = 16'h042F;  8'd25:  v = 16'h046F;  8'd26:  v = 16'h04B2;
            8'd27:  v = 16'h04FA;  8'd28:  v = 16'h0546;  8'd29:  v = 16'h0596;
            8'd30:  v = 16'h05EB;  8'd31:  v = 16'h0645;  8'd32:  v = 16'h06A5;
            8'd33:  v = 16'h070A;  8'd34:  v = 16'h0775;  8'd35:  v = 16'h07E6;
            8'd36:  v = 16'h085F;  8'd37:  v = 16'h08DE;  8'd38:  v = 16'h0965;
            8'd39:  v = 16'h09F4;  8'd40:  v = 16'h0A8C;  8'd41:  v = 16'h0B2C;
            8'd42:  v = 16'h0BD6;  8'd43:  v = 16'h0C8B;  8'd44:  v = 16'h0D4A;
            8'd45:  v = 16'h0E14;  8'd46:  v = 16'h0EEA;  8'd47:  v = 16'h0FCD;
            8'd48:  v = 16'h10BE;  8'd49:  v = 16'h11BD;  8'd50:  v = 16'h12CB;
            8'd51:  v = 16'h13E9;  8'd52:  v = 16'h1518;  8'd53:  v = 16'h1659;
            8'd54:  v = 16'h17AD;  8'd55:  v = 16'h1916;  8'd56:  v = 16'h1A94;
            8'd57:  v = 16'h1C28;  8'd58:  v = 16'h1DD5;  8'd59:  v = 16'h1F9B;
            8'd60:  v = 16'h217C;  8'd61:  v = 16'h237A;  8'd62:  v = 16'h2596;
            8'd63:  v = 16'h27D2;  8'd64:  v = 16'h2A30;  8'd65:  v = 16'h2CB2;
            8'd66:  v = 16'h2F5A;  8'd67:  v = 16'h322C;  8'd68:  v = 16'h3528;
            8'd69:  v = 16'h3850;  8'd70:  v = 16'h3BAC;  8'd71:  v = 16'h3F36;
            8'd72:  v = 16'h0021;  8'd73:  v = 16'h0023;  8'd74:  v = 16'h0026;
            8'd75:  v = 16'h0028;  8'd76:  v = 16'h002A;  8'd77:  v = 16'h002D;
            8'd78:  v = 16'h002F;  8'd79:  v = 16'h0032;  8'd80:  v = 16'h0035;
            8'd81:  v = 16'h0038;  8'd82:  v = 16'h003C;  8'd83:  v = 16'h003F;
            8'd84:  v = 16'h0042;  8'd85:  v = 16'h0046;  8'd86:  v = 16'h004B;
            8'd87:  v = 16'h004F;  8'd88:  v = 16'h0054;  8'd89:  v = 16'h0059;
            8'd90:  v = 16'h005E;  8'd91:  v = 16'h0064;  8'd92:  v = 16'h006A;
            8'd93:  v = 16'h0070;  8'd94:  v = 16'h0077;  8'd95:  v = 16'h007E;
            8'd96:  v = 16'h0085;  8'd97:  v = 16'h008D;  8'd98:  v = 16'h0096;
            8'd99:  v = 16'h009F;  8'd100: v = 16'h00A8;  8'd101: v = 16'h00B2;
            8'd102: v = 16'h00BD;  8'd103: v = 16'h00C8;  8'd104: v = 16'h00D4;
            8'd105: v = 16'h00E1;  8'd106: v = 16'h00EE;  8'd107: v = 16'h00FC;
            default: v = 16'h0000;
        endcase
        if (32'(addr) >= TABLE_ENTRIES) begin
            v = 16'h0000;
        end
        return v[PITCH_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/note_to_pitch_interpolator.sv -----
// ----------------------------------------------------------------------------
// note_to_pitch_interpolator - note word to voice pitch
// Tunes the note word, looks up two neighboring pitch table entries and
// linearly interpolates between them by the fraction byte.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------
//  input    in         i_valid / o_stall    i_voice, i_note_word, i_fine_tune,
//                                           i_note_offset
//  output   out        o_valid / i_stall    o_voice_out, o_pitch
//
//  Four register stages: tune, table lookup, multiply, sum. A transaction
//  passes through the tune, lookup, multiply and sum registers in that order,
//  and o_valid comes from the sum register; one transaction per cycle unless the pipe holds.
//  The pitch table is constant logic, read at two addresses in the lookup
//  stage, so it sets no rate limit.
//  Reset (synchronous, active low) clears only the stage valid bits.
//  The whole pipe holds while the output register is full and stalled; an
//  empty output register never blocks, and o_stall is exactly that hold.
//
module note_to_pitch_interpolator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transaction
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ntp_pkg::VOICE_W-1:0]       i_voice,
    input  logic [ntp_pkg::NOTE_W-1:0]        i_note_word,
    input  logic signed [ntp_pkg::TUNE_W-1:0] i_fine_tune,
    input  logic [ntp_pkg::OFFS_W-1:0]        i_note_offset,
    // result transaction
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ntp_pkg::VOICE_W-1:0]       o_voice_out,
    output logic [ntp_pkg::PITCH_W-1:0]       o_pitch
);

    localparam int HI_PART_W = ntp_pkg::DHI_W + ntp_pkg::FRAC_W;

    ntp_pkg::t_pipe_ctl ctl;

    // stage 1 -> 2
    logic                         s1_vld;
    ntp_pkg::t_voice              s1_voice;
    logic [ntp_pkg::IDX_W-1:0]    s1_idx;
    logic [ntp_pkg::FRAC_W-1:0]   s1_frac;
    // stage 2 -> 3
    logic                         s2_vld;
    ntp_pkg::t_voice              s2_voice;
    logic [ntp_pkg::FRAC_W-1:0]   s2_frac;
    ntp_pkg::t_pitch              s2_base;
    ntp_pkg::t_pitch              s2_diff;
    // stage 3 -> 4
    logic                         s3_vld;
    ntp_pkg::t_voice              s3_voice;
    ntp_pkg::t_pitch              s3_base;
    logic [ntp_pkg::DLO_W-1:0]    s3_lo_part;
    logic [HI_PART_W-1:0]         s3_hi_part;
    // stage 4 (output register)
    logic                         s4_vld;

    // Pipe advances unless a finished result sits stalled at the output.
    always_comb begin
        ctl.en  = !(s4_vld && i_stall);
        o_stall = !ctl.en;
    end

    ntp_tune_stage u_tune (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_vld        (i_valid),
        .i_voice      (i_voice),
        .i_note_word  (i_note_word),
        .i_fine_tune  (i_fine_tune),
        .i_note_offset(i_note_offset),
        .o_vld        (s1_vld),
        .o_voice      (s1_voice),
        .o_idx        (s1_idx),
        .o_frac       (s1_frac)
    );

    ntp_rom_stage u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_vld   (s1_vld),
        .i_voice (s1_voice),
        .i_idx   (s1_idx),
        .i_frac  (s1_frac),
        .o_vld   (s2_vld),
        .o_voice (s2_voice),
        .o_frac  (s2_frac),
        .o_base  (s2_base),
        .o_diff  (s2_diff)
    );

    ntp_mul_stage u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_vld     (s2_vld),
        .i_voice   (s2_voice),
        .i_frac    (s2_frac),
        .i_base    (s2_base),
        .i_diff    (s2_diff),
        .o_vld     (s3_vld),
        .o_voice   (s3_voice),
        .o_base    (s3_base),
        .o_lo_part (s3_lo_part),
        .o_hi_part (s3_hi_part)
    );

    ntp_sum_stage u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_vld     (s3_vld),
        .i_voice   (s3_voice),
        .i_base    (s3_base),
        .i_lo_part (s3_lo_part),
        .i_hi_part (s3_hi_part),
        .o_vld     (s4_vld),
        .o_voice   (o_voice_out),
        .o_pitch   (o_pitch)
    );

    assign o_valid = s4_vld;

endmodule

// ----- hw/rtl/ntp_tune_stage.sv -----
// ----------------------------------------------------------------------------
// ntp_tune_stage - note word tuning
// Adds fine-tune to the note word, then the note offset to the note byte.
// ----------------------------------------------------------------------------
module ntp_tune_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ntp_pkg::t_pipe_ctl                i_ctl,
    input  logic                              i_vld,
    input  ntp_pkg::t_voice                   i_voice,
    input  logic [ntp_pkg::NOTE_W-1:0]        i_note_word,
    input  logic signed [ntp_pkg::TUNE_W-1:0] i_fine_tune,
    input  logic [ntp_pkg::OFFS_W-1:0]        i_note_offset,
    output logic                              o_vld,
    output ntp_pkg::t_voice                   o_voice,
    output logic [ntp_pkg::IDX_W-1:0]         o_idx,
    output logic [ntp_pkg::FRAC_W-1:0]        o_frac
);

    logic [ntp_pkg::NOTE_W-1:0] n_word;
    logic [ntp_pkg::IDX_W-1:0]  n_idx;

    logic                         r_vld;
    ntp_pkg::t_voice              r_voice;
    logic [ntp_pkg::IDX_W-1:0]    r_idx;
    logic [ntp_pkg::FRAC_W-1:0]   r_frac;

    always_comb begin
        n_word = i_note_word + ntp_pkg::NOTE_W'(i_fine_tune);   // sign-extended, wraps
        // only 7 index bits survive, so the add is kept that narrow
        n_idx  = n_word[ntp_pkg::FRAC_W +: ntp_pkg::IDX_W]
               + i_note_offset[ntp_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_voice <= i_voice;
            r_idx   <= n_idx;
            r_frac  <= n_word[ntp_pkg::FRAC_W-1:0];
        end
    end

    assign o_vld   = r_vld;
    assign o_voice = r_voice;
    assign o_idx   = r_idx;
    assign o_frac  = r_frac;

endmodule

// ----- hw/rtl/ntp_rom_stage.sv -----
// ----------------------------------------------------------------------------
// ntp_rom_stage - table lookup
// Reads the two neighboring table entries and forms their step.
// ----------------------------------------------------------------------------
module ntp_rom_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ntp_pkg::t_pipe_ctl            i_ctl,
    input  logic                          i_vld,
    input  ntp_pkg::t_voice               i_voice,
    input  logic [ntp_pkg::IDX_W-1:0]     i_idx,
    input  logic [ntp_pkg::FRAC_W-1:0]    i_frac,
    output logic                          o_vld,
    output ntp_pkg::t_voice               o_voice,
    output logic [ntp_pkg::FRAC_W-1:0]    o_frac,
    output ntp_pkg::t_pitch               o_base,
    output ntp_pkg::t_pitch               o_diff
);

    logic [ntp_pkg::ADDR_W-1:0] n_addr_next;
    ntp_pkg::t_pitch            n_base;
    ntp_pkg::t_pitch            n_next;
    ntp_pkg::t_pitch            n_diff;

    logic                         r_vld;
    ntp_pkg::t_voice              r_voice;
    logic [ntp_pkg::FRAC_W-1:0]   r_frac;
    ntp_pkg::t_pitch              r_base;
    ntp_pkg::t_pitch              r_diff;

    always_comb begin
        n_addr_next = {1'b0, i_idx} + ntp_pkg::ADDR_W'(1);
        n_base      = ntp_pkg::pitch_rom({1'b0, i_idx});
        n_next      = ntp_pkg::pitch_rom(n_addr_next);
        // downward step (octave wrap or end of table) uses a fixed step
        if (n_next < n_base) begin
            n_diff = ntp_pkg::NEG_DIFF;
        end else begin
            n_diff = n_next - n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_voice <= i_voice;
            r_frac  <= i_frac;
            r_base  <= n_base;
            r_diff  <= n_diff;
        end
    end

    assign o_vld   = r_vld;
    assign o_voice = r_voice;
    assign o_frac  = r_frac;
    assign o_base  = r_base;
    assign o_diff  = r_diff;

endmodule

// ----- hw/rtl/ntp_mul_stage.sv -----
// ----------------------------------------------------------------------------
// ntp_mul_stage - fraction scaling
// Multiplies the low byte and the high six bits of the step by the fraction.
// ----------------------------------------------------------------------------
module ntp_mul_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ntp_pkg::t_pipe_ctl                  i_ctl,
    input  logic                                i_vld,
    input  ntp_pkg::t_voice                     i_voice,
    input  logic [ntp_pkg::FRAC_W-1:0]          i_frac,
    input  ntp_pkg::t_pitch                     i_base,
    input  ntp_pkg::t_pitch                     i_diff,
    output logic                                o_vld,
    output ntp_pkg::t_voice                     o_voice,
    output ntp_pkg::t_pitch                     o_base,
    output logic [ntp_pkg::DLO_W-1:0]           o_lo_part,
    output logic [ntp_pkg::DHI_W+ntp_pkg::FRAC_W-1:0] o_hi_part
);

    localparam int LO_PROD_W = ntp_pkg::DLO_W + ntp_pkg::FRAC_W;
    localparam int HI_PROD_W = ntp_pkg::DHI_W + ntp_pkg::FRAC_W;

    logic [LO_PROD_W-1:0] n_lo_prod;
    logic [HI_PROD_W-1:0] n_hi_prod;

    logic                         r_vld;
    ntp_pkg::t_voice              r_voice;
    ntp_pkg::t_pitch              r_base;
    logic [ntp_pkg::DLO_W-1:0]    r_lo_part;
    logic [HI_PROD_W-1:0]         r_hi_part;

    always_comb begin
        n_lo_prod = LO_PROD_W'(i_diff[ntp_pkg::DLO_W-1:0]) * LO_PROD_W'(i_frac);
        n_hi_prod = HI_PROD_W'(i_diff[ntp_pkg::PITCH_W-1:ntp_pkg::DLO_W])
                  * HI_PROD_W'(i_frac);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_voice   <= i_voice;
            r_base    <= i_base;
            r_lo_part <= n_lo_prod[LO_PROD_W-1:ntp_pkg::FRAC_W];   // drop fraction bits
            r_hi_part <= n_hi_prod;
        end
    end

    assign o_vld     = r_vld;
    assign o_voice   = r_voice;
    assign o_base    = r_base;
    assign o_lo_part = r_lo_part;
    assign o_hi_part = r_hi_part;

endmodule

// ----- hw/rtl/ntp_sum_stage.sv -----
// ----------------------------------------------------------------------------
// ntp_sum_stage - pitch sum and output register
// Adds both scaled parts to the base entry and holds the result transaction.
// ----------------------------------------------------------------------------
module ntp_sum_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ntp_pkg::t_pipe_ctl                  i_ctl,
    input  logic                                i_vld,
    input  ntp_pkg::t_voice                     i_voice,
    input  ntp_pkg::t_pitch                     i_base,
    input  logic [ntp_pkg::DLO_W-1:0]           i_lo_part,
    input  logic [ntp_pkg::DHI_W+ntp_pkg::FRAC_W-1:0] i_hi_part,
    output logic                                o_vld,
    output ntp_pkg::t_voice                     o_voice,
    output ntp_pkg::t_pitch                     o_pitch
);

    ntp_pkg::t_pitch n_pitch;

    logic             r_vld;
    ntp_pkg::t_voice  r_voice;
    ntp_pkg::t_pitch  r_pitch;

    // sum wraps at 14 bits
    assign n_pitch = i_base + ntp_pkg::PITCH_W'(i_lo_part) + i_hi_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_voice <= i_voice;
            r_pitch <= n_pitch;
        end
    end

    assign o_vld   = r_vld;
    assign o_voice = r_voice;
    assign o_pitch = r_pitch;

endmodule
